>>> src/plsolv_pkg.sv
// Shared types, widths and codes of the power-limited current solver.
// No dependencies; every other file of the block imports this package.
package plsolv_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned XW        = 32;              // word width of Q values except the power factor
  localparam int unsigned PF_W      = 17;              // power factor width
  localparam int unsigned ONE       = 1 << FRAC_BITS;  // 1.0 in Q.F

  localparam int unsigned BM_W   = 2 * XW - FRAC_BITS;   // |b|
  localparam int unsigned BH_W   = BM_W / 2;             // half of |b| for squaring
  localparam int unsigned BSQ_W  = 2 * BM_W;             // b*b
  localparam int unsigned WSQ_W  = 2 * XW - 1;           // w*w
  localparam int unsigned WL_W   = XW - 1;               // low slice of w*w
  localparam int unsigned KP_W   = 3 * XW - 2;           // |k1|*w*w
  localparam int unsigned CM_W   = KP_W - 2 * FRAC_BITS; // |c|
  localparam int unsigned C_W    = CM_W + 2;             // signed c
  localparam int unsigned CH_W   = CM_W / 2;             // low slice of |c|
  localparam int unsigned T_W    = CM_W + XW + 2;        // |4*k2*c|
  localparam int unsigned DISC_W = BSQ_W + 2;            // discriminant magnitude
  localparam int unsigned ROOT_W = DISC_W / 2;           // isqrt result
  localparam int unsigned NM_W   = ROOT_W + 1;           // |-b +/- h|
  localparam int unsigned DV_W   = XW + 1;               // divisor 2*|k2|
  localparam int unsigned QB_W   = XW + 1;               // quotient bits kept
  localparam int unsigned PP_W   = PF_W + XW;            // factor*P
  localparam int unsigned PT_W   = PP_W - FRAC_BITS;     // trunc(factor*P)

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IN_W       = 3 * XW;
  localparam int unsigned ST_W       = 2;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_K2ZERO,
    KIND_LIMIT
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    STAT_PASS   = 2'd0,
    STAT_ROOT   = 2'd1,
    STAT_NOROOT = 2'd2,
    STAT_K2ZERO = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K0 = 3'd0,
    CFG_K1 = 3'd1,
    CFG_K2 = 3'd2,
    CFG_A0 = 3'd3,
    CFG_PF = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [XW-1:0]   k0;
    logic [XW-1:0]   k1;
    logic [XW-1:0]   k2;
    logic [XW-1:0]   a0;
    logic [PF_W-1:0] pf;
  } cfg_t;

  typedef struct packed {
    kind_e         kind;
    logic [XW-1:0] req;
    logic [XW-1:0] w;
    logic [XW-1:0] p;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> src/power_limited_current_solver.sv
// Top level of the power-limited current solver: configuration registers,
// front end, queue and arithmetic back end. Depends on plsolv_pkg and all plsolv_* modules.
//
// Takes one item per clock while the output is not stalled and returns one result
// per item, in order. Most of the back end depth lies in the 49-stage square-root
// pipeline and the 33-stage two-lane root divider; both are fully pipelined so
// throughput is one item per cycle when the output is not stalled. A stalled output
// freezes the back end; a two-entry queue and the front register absorb the
// input side before s_axis_tready drops. Registers (index: k0, k1, k2, a0,
// power factor) are written through the cfg port, which is always ready, and
// must only be changed while no item is in flight.
module power_limited_current_solver #(
  parameter int unsigned FifoDepth = plsolv_pkg::FIFO_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [plsolv_pkg::IN_W-1:0]      s_axis_tdata,  // est_power, speed, current_request
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [plsolv_pkg::XW-1:0]        m_axis_tdata,  // current_out
  output logic [plsolv_pkg::ST_W-1:0]      m_axis_tuser,  // status
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [plsolv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [plsolv_pkg::XW-1:0]        cfg_data_i
);
  import plsolv_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       push;
  item_t      front_item, fifo_item;
  fifo_stat_t fifo_stat;
  logic       pop;
  status_e    status;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_K0:  cfg_d.k0 = cfg_data_i;
        CFG_K1:  cfg_d.k1 = cfg_data_i;
        CFG_K2:  cfg_d.k2 = cfg_data_i;
        CFG_A0:  cfg_d.a0 = cfg_data_i;
        CFG_PF:  cfg_d.pf = cfg_data_i[PF_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k0 <= '0;
      cfg_q.k1 <= '0;
      cfg_q.k2 <= XW'(ONE);
      cfg_q.a0 <= '0;
      cfg_q.pf <= PF_W'(ONE);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  plsolv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .fifo_full_i   (fifo_stat.full),
    .push_o        (push),
    .item_o        (front_item)
  );

  plsolv_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_item),
    .pop_i  (pop),
    .data_o (fifo_item),
    .stat_o (fifo_stat)
  );

  plsolv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .fifo_empty_i  (fifo_stat.empty),
    .item_i        (fifo_item),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_current_o (m_axis_tdata),
    .out_status_o  (status)
  );

  assign m_axis_tuser = status;

  // no-root and k2-zero results always carry zero current
  a_zero_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == STAT_NOROOT || status == STAT_K2ZERO)
      |-> m_axis_tdata == '0)
    else $error("zero-current status with nonzero current");

  // the input side only stalls once the queue is full
  a_front_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> fifo_stat.full)
    else $error("input stalled with room in the queue");

  // k2-zero status can only come from a cleared k2 register
  a_k2_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == STAT_K2ZERO |-> cfg_q.k2 == '0)
    else $error("k2-zero status with nonzero k2");

endmodule

>>> src/plsolv_front.sv
// Front end: takes input transactions, splits the payload and classifies each item.
// Depends on plsolv_pkg; hands items to the queue in front of plsolv_back.
module plsolv_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  plsolv_pkg::cfg_t           cfg_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [plsolv_pkg::IN_W-1:0] s_axis_tdata,  // est_power, speed, current_request
  input  logic                       fifo_full_i,
  output logic                       push_o,
  output plsolv_pkg::item_t          item_o
);
  import plsolv_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q, item_d;
  logic  take;
  logic  p_pos;

  assign push_o        = vld_q && !fifo_full_i;
  assign s_axis_tready = !vld_q || !fifo_full_i;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign item_o        = item_q;

  assign p_pos = !s_axis_tdata[XW-1] && (s_axis_tdata[XW-1:0] != '0);

  always_comb begin
    item_d.p   = s_axis_tdata[XW-1:0];
    item_d.w   = s_axis_tdata[2*XW-1:XW];
    item_d.req = s_axis_tdata[3*XW-1:2*XW];
    if (!p_pos || (cfg_i.pf >= PF_W'(ONE))) begin
      item_d.kind = KIND_PASS;
    end else if (cfg_i.k2 == '0) begin
      item_d.kind = KIND_K2ZERO;
    end else begin
      item_d.kind = KIND_LIMIT;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

>>> src/plsolv_fifo.sv
// Short queue between the front end and the arithmetic back end.
// Depends on plsolv_pkg for the status struct.
module plsolv_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      data_i,
  input  logic                  pop_i,
  output logic [WIDTH-1:0]      data_o,
  output plsolv_pkg::fifo_stat_t stat_o
);
  import plsolv_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> src/plsolv_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband that
// travels alongside. Depends on plsolv_pkg for the radicand and root widths.
module plsolv_isqrt #(
  parameter int unsigned SB_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [plsolv_pkg::DISC_W-1:0] rad_i,
  input  logic [SB_W-1:0]               sb_i,
  output logic                          vld_o,
  output logic [plsolv_pkg::ROOT_W-1:0] root_o,
  output logic [SB_W-1:0]               sb_o
);
  import plsolv_pkg::*;

  localparam int unsigned RM_W = ROOT_W + 3;

  logic              vld_q  [ROOT_W];
  logic [DISC_W-1:0] rad_q  [ROOT_W];
  logic [RM_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SB_W-1:0]   sb_q   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              pv;
    logic [DISC_W-1:0] prad;
    logic [RM_W-1:0]   prem, remx, trial;
    logic [ROOT_W-1:0] proot;
    logic [SB_W-1:0]   psb;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv    = vld_i;
      assign prad  = rad_i;
      assign prem  = '0;
      assign proot = '0;
      assign psb   = sb_i;
    end else begin : g_next
      assign pv    = vld_q[k-1];
      assign prad  = rad_q[k-1];
      assign prem  = rem_q[k-1];
      assign proot = root_q[k-1];
      assign psb   = sb_q[k-1];
    end

    // rem holds (radicand prefix - root^2); trial is 4*root + 1
    assign remx  = {prem[RM_W-3:0], prad[DISC_W-1 -: 2]};
    assign trial = {1'b0, proot, 2'b01};
    assign ge    = (remx >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {prad[DISC_W-3:0], 2'b00};
        rem_q[k]  <= ge ? (remx - trial) : remx;
        root_q[k] <= {proot[ROOT_W-2:0], ge};
        sb_q[k]   <= psb;
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign sb_o   = sb_q[ROOT_W-1];

endmodule

>>> src/plsolv_div.sv
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per
// stage, with overflow flag for quotients past the kept bits. Depends on plsolv_pkg.
module plsolv_div #(
  parameter int unsigned SB_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [plsolv_pkg::NM_W-1:0] num_i [2],
  input  logic [plsolv_pkg::DV_W-1:0] den_i,
  input  logic [SB_W-1:0]             sb_i,
  output logic                        vld_o,
  output logic [plsolv_pkg::QB_W-1:0] quo_o [2],
  output logic                        ovf_o [2],
  output logic [SB_W-1:0]             sb_o
);
  import plsolv_pkg::*;

  // dividend is num << FRAC_BITS; the part above the kept quotient bits seeds the remainder
  localparam int unsigned LO_N = QB_W - FRAC_BITS;

  logic            vld_q [QB_W];
  logic [SB_W-1:0] sb_q  [QB_W];
  logic [DV_W-1:0] rem_q [QB_W][2];
  logic [QB_W-1:0] nlo_q [QB_W][2];
  logic [QB_W-1:0] quo_q [QB_W][2];
  logic            ovf_q [QB_W][2];

  for (genvar k = 0; k < QB_W; k++) begin : g_stage
    logic            pv;
    logic [SB_W-1:0] psb;

    if (k == 0) begin : g_first
      assign pv  = vld_i;
      assign psb = sb_i;
    end else begin : g_next
      assign pv  = vld_q[k-1];
      assign psb = sb_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[k] <= psb;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DV_W-1:0] prem;
      logic [QB_W-1:0] pnlo, pquo;
      logic            povf;
      logic [DV_W:0]   rem2, sub;
      logic            ge;

      if (k == 0) begin : g_first
        assign prem = num_i[l][NM_W-1:LO_N];
        assign pnlo = {num_i[l][LO_N-1:0], {FRAC_BITS{1'b0}}};
        assign pquo = '0;
        assign povf = (num_i[l][NM_W-1:LO_N] >= den_i);
      end else begin : g_next
        assign prem = rem_q[k-1][l];
        assign pnlo = nlo_q[k-1][l];
        assign pquo = quo_q[k-1][l];
        assign povf = ovf_q[k-1][l];
      end

      assign rem2 = {prem, pnlo[QB_W-1]};
      assign sub  = rem2 - {1'b0, den_i};
      assign ge   = (rem2 >= {1'b0, den_i});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? sub[DV_W-1:0] : rem2[DV_W-1:0];
          nlo_q[k][l] <= {pnlo[QB_W-2:0], 1'b0};
          quo_q[k][l] <= {pquo[QB_W-2:0], ge};
          ovf_q[k][l] <= povf;
        end
      end
    end
  end

  assign vld_o = vld_q[QB_W-1];
  assign sb_o  = sb_q[QB_W-1];
  for (genvar l = 0; l < 2; l++) begin : g_out
    assign quo_o[l] = quo_q[QB_W-1][l];
    assign ovf_o[l] = ovf_q[QB_W-1][l];
  end

endmodule

>>> src/plsolv_back.sv
// Back end: coefficient products, discriminant, square root, root division,
// saturation and root selection, ending in the output register.
// Depends on plsolv_pkg, plsolv_isqrt and plsolv_div.
module plsolv_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  plsolv_pkg::cfg_t                  cfg_i,
  input  logic                              fifo_empty_i,
  input  plsolv_pkg::item_t                 item_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [plsolv_pkg::XW-1:0]         out_current_o,
  output plsolv_pkg::status_e               out_status_o
);
  import plsolv_pkg::*;

  localparam logic [QB_W-1:0] QMAXN = QB_W'(1) << (XW - 1);

  typedef struct packed {
    kind_e           kind;
    logic [XW-1:0]   req;
    logic            bneg;
    logic [BM_W-1:0] bm;
  } side_t;

  typedef struct packed {
    side_t sd;
    logic  dneg;
  } sqsb_t;

  typedef struct packed {
    kind_e         kind;
    logic [XW-1:0] req;
    logic          dneg;
    logic          n1neg;
    logic          n2neg;
  } dvsb_t;

  function automatic logic [XW-1:0] mag32(input logic [XW-1:0] x);
    return x[XW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [XW-1:0] sat_root(input logic [QB_W-1:0] q, input logic ovf,
                                             input logic neg);
    logic [XW-1:0] r;
    if (neg) begin
      r = (ovf || q > QMAXN) ? {1'b1, {(XW-1){1'b0}}} : (~q[XW-1:0] + 1'b1);
    end else begin
      r = (ovf || q > QMAXN - 1'b1) ? {1'b0, {(XW-1){1'b1}}} : q[XW-1:0];
    end
    return r;
  endfunction

  logic en;
  logic out_vld_q;
  logic [XW-1:0] out_cur_q, out_cur_d;
  status_e out_st_q, out_st_d;

  assign en    = !out_vld_q || out_ready_i;
  assign pop_o = en && !fifo_empty_i;

  logic [XW-1:0] k0m, k1m, k2m, wm;
  assign k0m = mag32(cfg_i.k0);
  assign k1m = mag32(cfg_i.k1);
  assign k2m = mag32(cfg_i.k2);
  assign wm  = mag32(item_i.w);

  // ---- stage 1: k0*w, w*w, factor*P
  logic            v1_q;
  kind_e           kind1_q;
  logic [XW-1:0]   req1_q;
  logic            bneg1_q;
  logic [2*XW-1:0] bf1_q, bf_d, wsqf;
  logic [WSQ_W-1:0] wsq1_q;
  logic [PP_W-1:0] pp1_q, pp_d;

  assign bf_d = k0m * wm;
  assign wsqf = wm * wm;
  assign pp_d = cfg_i.pf * item_i.p;

  // ---- stage 2: split products for k1*w*w and b*b
  logic            v2_q;
  side_t           sd2_q;
  logic [BM_W-1:0] bm_d;
  logic [XW+WL_W-1:0] kpl2_q, kpl_d;
  logic [2*XW-1:0] kph2_q, kph_d;
  logic [BM_W-1:0] hh2_q, hl2_q, ll2_q, hh_d, hl_d, ll_d;
  logic [PT_W-1:0] pt2_q;

  assign bm_d  = bf1_q[2*XW-1:FRAC_BITS];
  assign kpl_d = k1m * wsq1_q[WL_W-1:0];
  assign kph_d = k1m * wsq1_q[WSQ_W-1:WL_W];
  assign hh_d  = bm_d[BM_W-1:BH_W] * bm_d[BM_W-1:BH_W];
  assign hl_d  = bm_d[BM_W-1:BH_W] * bm_d[BH_W-1:0];
  assign ll_d  = bm_d[BH_W-1:0] * bm_d[BH_W-1:0];

  // ---- stage 3: sum partial products
  logic             v3_q;
  side_t            sd3_q;
  logic [KP_W-1:0]  k1p_d;
  logic [CM_W-1:0]  k1t3_q;
  logic [PT_W-1:0]  pt3_q;
  logic [BSQ_W-1:0] bsq3_q, bsq_d;

  assign k1p_d = (KP_W'(kph2_q) << WL_W) + KP_W'(kpl2_q);
  assign bsq_d = (BSQ_W'(hh2_q) << (2 * BH_W)) + (BSQ_W'(hl2_q) << (BH_W + 1))
               + BSQ_W'(ll2_q);

  // ---- stage 4: c = a0 + k1*w^2 - factor*P
  logic             v4_q;
  side_t            sd4_q;
  logic [BSQ_W-1:0] bsq4_q;
  logic [C_W-1:0]   c4_q, c_d, k1x;

  assign k1x = {2'b00, k1t3_q};
  assign c_d = {{(C_W-XW){cfg_i.a0[XW-1]}}, cfg_i.a0}
             + (cfg_i.k1[XW-1] ? (~k1x + 1'b1) : k1x)
             - {{(C_W-PT_W){1'b0}}, pt3_q};

  // ---- stage 5: |c| * |k2| partials
  logic             v5_q;
  side_t            sd5_q;
  logic [BSQ_W-1:0] bsq5_q;
  logic             tneg5_q;
  logic [C_W-1:0]   cabs;
  logic [CM_W-1:0]  cm;
  logic [CH_W+XW-1:0] tl5_q, th5_q, tl_d, th_d;

  assign cabs = c4_q[C_W-1] ? (~c4_q + 1'b1) : c4_q;
  assign cm   = cabs[CM_W-1:0];
  assign tl_d = cm[CH_W-1:0] * k2m;
  assign th_d = cm[CM_W-1:CH_W] * k2m;

  // ---- stage 6: |4*k2*c|
  logic             v6_q;
  side_t            sd6_q;
  logic [BSQ_W-1:0] bsq6_q;
  logic             tneg6_q;
  logic [T_W-1:0]   tm6_q, tm_d;

  assign tm_d = ((T_W'(th5_q) << CH_W) + T_W'(tl5_q)) << 2;

  // ---- stage 7: discriminant
  logic              v7_q;
  sqsb_t             sq7_q;
  logic [DISC_W-1:0] rad7_q;
  logic [DISC_W:0]   dsum;

  assign dsum = tneg6_q ? ({3'b000, bsq6_q} + {1'b0, tm6_q})
                        : ({3'b000, bsq6_q} - {1'b0, tm6_q});

  // ---- square root
  logic              sqv;
  logic [ROOT_W-1:0] hroot;
  sqsb_t             sqo;

  plsolv_isqrt #(
    .SB_W ($bits(sqsb_t))
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v7_q),
    .rad_i  (rad7_q),
    .sb_i   (sq7_q),
    .vld_o  (sqv),
    .root_o (hroot),
    .sb_o   (sqo)
  );

  // ---- stage 8: numerators -b + h and -b - h
  logic            v8_q;
  dvsb_t           dv8_q, dv_d;
  logic [NM_W-1:0] n8_q [2];
  logic [NM_W:0]   nb, hx, n1, n2, a1, a2;

  assign nb = sqo.sd.bneg ? {{(NM_W+1-BM_W){1'b0}}, sqo.sd.bm}
                          : (~{{(NM_W+1-BM_W){1'b0}}, sqo.sd.bm} + 1'b1);
  assign hx = {2'b00, hroot};
  assign n1 = nb + hx;
  assign n2 = nb - hx;
  assign a1 = n1[NM_W] ? (~n1 + 1'b1) : n1;
  assign a2 = n2[NM_W] ? (~n2 + 1'b1) : n2;

  always_comb begin
    dv_d.kind  = sqo.sd.kind;
    dv_d.req   = sqo.sd.req;
    dv_d.dneg  = sqo.dneg;
    dv_d.n1neg = n1[NM_W];
    dv_d.n2neg = n2[NM_W];
  end

  // ---- division by 2*k2
  logic            dvv;
  logic [QB_W-1:0] quo [2];
  logic            ovf [2];
  dvsb_t           dvo;

  plsolv_div #(
    .SB_W ($bits(dvsb_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v8_q),
    .num_i  (n8_q),
    .den_i  ({k2m, 1'b0}),
    .sb_i   (dv8_q),
    .vld_o  (dvv),
    .quo_o  (quo),
    .ovf_o  (ovf),
    .sb_o   (dvo)
  );

  // ---- stage 9: saturate roots
  logic          v9_q;
  dvsb_t         dv9_q;
  logic [XW-1:0] r1_q, r2_q;

  // ---- output stage: select root and status
  logic signed [XW:0] e1, e2, m1, m2;
  logic signed [XW-1:0] s1, s2, sr;
  logic opp, match;

  assign s1 = r1_q;
  assign s2 = r2_q;
  assign sr = dv9_q.req;
  assign e1 = {r1_q[XW-1], r1_q};
  assign e2 = {r2_q[XW-1], r2_q};
  assign m1 = (e1 < 0) ? -e1 : e1;
  assign m2 = (e2 < 0) ? -e2 : e2;
  assign opp   = (s1 > 0 && s2 < 0) || (s1 < 0 && s2 > 0);
  assign match = (sr > 0 && s1 > 0) || (sr < 0 && s1 < 0);

  always_comb begin
    out_cur_d = '0;
    out_st_d  = STAT_PASS;
    case (dv9_q.kind)
      KIND_PASS: begin
        out_cur_d = dv9_q.req;
        out_st_d  = STAT_PASS;
      end
      KIND_K2ZERO: begin
        out_cur_d = '0;
        out_st_d  = STAT_K2ZERO;
      end
      KIND_LIMIT: begin
        if (dv9_q.dneg) begin
          out_cur_d = '0;
          out_st_d  = STAT_NOROOT;
        end else begin
          out_st_d = STAT_ROOT;
          if (opp) begin
            out_cur_d = match ? r1_q : r2_q;
          end else begin
            out_cur_d = (m1 < m2) ? r1_q : r2_q;
          end
        end
      end
      default: begin
        out_cur_d = '0;
        out_st_d  = STAT_PASS;
      end
    endcase
  end

  // ---- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      v7_q      <= 1'b0;
      v8_q      <= 1'b0;
      v9_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= pop_o;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      v7_q      <= v6_q;
      v8_q      <= sqv;
      v9_q      <= dvv;
      out_vld_q <= v9_q;
    end
  end

  // ---- payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      kind1_q <= item_i.kind;
      req1_q  <= item_i.req;
      bneg1_q <= cfg_i.k0[XW-1] ^ item_i.w[XW-1];
      bf1_q   <= bf_d;
      wsq1_q  <= wsqf[WSQ_W-1:0];
      pp1_q   <= pp_d;

      sd2_q.kind <= kind1_q;
      sd2_q.req  <= req1_q;
      sd2_q.bneg <= bneg1_q;
      sd2_q.bm   <= bm_d;
      kpl2_q     <= kpl_d;
      kph2_q     <= kph_d;
      hh2_q      <= hh_d;
      hl2_q      <= hl_d;
      ll2_q      <= ll_d;
      pt2_q      <= pp1_q[PP_W-1:FRAC_BITS];

      sd3_q  <= sd2_q;
      k1t3_q <= k1p_d[KP_W-1:2*FRAC_BITS];
      pt3_q  <= pt2_q;
      bsq3_q <= bsq_d;

      sd4_q  <= sd3_q;
      bsq4_q <= bsq3_q;
      c4_q   <= c_d;

      sd5_q   <= sd4_q;
      bsq5_q  <= bsq4_q;
      tneg5_q <= c4_q[C_W-1] ^ cfg_i.k2[XW-1];
      tl5_q   <= tl_d;
      th5_q   <= th_d;

      sd6_q   <= sd5_q;
      bsq6_q  <= bsq5_q;
      tneg6_q <= tneg5_q;
      tm6_q   <= tm_d;

      sq7_q.sd   <= sd6_q;
      sq7_q.dneg <= dsum[DISC_W];
      rad7_q     <= dsum[DISC_W] ? '0 : dsum[DISC_W-1:0];

      dv8_q   <= dv_d;
      n8_q[0] <= a1[NM_W-1:0];
      n8_q[1] <= a2[NM_W-1:0];

      dv9_q <= dvo;
      r1_q  <= sat_root(quo[0], ovf[0], dvo.n1neg ^ cfg_i.k2[XW-1]);
      r2_q  <= sat_root(quo[1], ovf[1], dvo.n2neg ^ cfg_i.k2[XW-1]);

      out_cur_q <= out_cur_d;
      out_st_q  <= out_st_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_current_o = out_cur_q;
  assign out_status_o  = out_st_q;

endmodule

>>> tb/power_limited_current_solver_chk.sv
// Checker for the power-limited current solver: watches the input, output and
// register channels, predicts each result and compares. Depends on plsolv_pkg.
module power_limited_current_solver_chk
  import plsolv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [XW-1:0]        m_axis_tdata,
  input  logic [ST_W-1:0]      m_axis_tuser,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [XW-1:0]        cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic [XW-1:0] current;
    status_e       status;
  } limited_t;

  limited_t  expected_q[$];
  cfg_t      regs;

  function automatic logic [63:0] sqrt_floor(wide_t d);
    logic [63:0] r;
    logic [63:0] t;
    wide_t       tw;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t  = r | (64'd1 << b);
      tw = {96'd0, t};
      if (tw * tw <= d) r = t;
    end
    return r;
  endfunction

  function automatic logic [XW-1:0] clamp_word(wide_t v);
    if (v > wide_t'(32'sh7fffffff)) return 32'h7fffffff;
    if (v < -wide_t'(64'sh80000000)) return 32'h80000000;
    return v[XW-1:0];
  endfunction

  // Root numerator over 2*k2, with the shift by FRAC_BITS; truncates toward zero
  function automatic logic signed [XW-1:0] root_of(wide_t num, wide_t k2);
    wide_t nm;
    wide_t km;
    wide_t q;
    nm = num < 0 ? -num : num;
    km = k2 < 0 ? -k2 : k2;
    q  = (nm <<< FRAC_BITS) / (2 * km);
    if ((num < 0) != (k2 < 0)) q = -q;
    return clamp_word(q);
  endfunction

  function automatic limited_t limit_current(logic [IN_W-1:0] d, cfg_t c);
    limited_t               res;
    wide_t                  p, w, req, k0, k1, k2, a0, pf;
    wide_t                  wm, bm, b, k1t, cc, disc, h;
    logic signed [XW-1:0]   r1, r2, rq;
    p   = $signed(d[XW-1:0]);
    w   = $signed(d[2*XW-1:XW]);
    rq  = $signed(d[3*XW-1:2*XW]);
    req = rq;
    k0  = $signed(c.k0);
    k1  = $signed(c.k1);
    k2  = $signed(c.k2);
    a0  = $signed(c.a0);
    pf  = {143'd0, c.pf};
    if (p <= 0 || pf >= ONE) begin
      res.current = rq;
      res.status  = STAT_PASS;
    end else if (k2 == 0) begin
      res.current = '0;
      res.status  = STAT_K2ZERO;
    end else begin
      wm  = w < 0 ? -w : w;
      bm  = ((k0 < 0 ? -k0 : k0) * wm) >>> FRAC_BITS;
      b   = ((k0 < 0) != (w < 0)) ? -bm : bm;
      k1t = ((k1 < 0 ? -k1 : k1) * wm * wm) >>> (2 * FRAC_BITS);
      cc  = a0 + (k1 < 0 ? -k1t : k1t) - ((pf * p) >>> FRAC_BITS);
      disc = bm * bm - 4 * k2 * cc;
      if (disc < 0) begin
        res.current = '0;
        res.status  = STAT_NOROOT;
      end else begin
        h  = {96'd0, sqrt_floor(disc)};
        r1 = root_of(-b + h, k2);
        r2 = root_of(-b - h, k2);
        if ((r1 > 0 && r2 < 0) || (r1 < 0 && r2 > 0)) begin
          res.current = ((rq > 0 && r1 > 0) || (rq < 0 && r1 < 0)) ? r1 : r2;
        end else begin
          // smaller magnitude wins, ties to the second root
          res.current = ((r1 < 0 ? -wide_t'(r1) : wide_t'(r1)) <
                         (r2 < 0 ? -wide_t'(r2) : wide_t'(r2))) ? r1 : r2;
        end
        res.status = STAT_ROOT;
      end
    end
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    limited_t exp_r;
    if (!rst_ni) begin
      regs.k0  = '0;
      regs.k1  = '0;
      regs.k2  = 32'd65536;
      regs.a0  = '0;
      regs.pf  = 17'd65536;
      errors_o = 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: current_out %h status %0d", m_axis_tdata, m_axis_tuser);
          errors_o++;
        end else begin
          exp_r = expected_q.pop_front();
          if (m_axis_tdata !== exp_r.current) begin
            $error("current_out: expected %h actual %h", exp_r.current, m_axis_tdata);
            errors_o++;
          end
          if (m_axis_tuser !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, m_axis_tuser);
            errors_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(limit_current(s_axis_tdata, regs));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_K0: regs.k0 = cfg_data_i;
          CFG_K1: regs.k1 = cfg_data_i;
          CFG_K2: regs.k2 = cfg_data_i;
          CFG_A0: regs.a0 = cfg_data_i;
          CFG_PF: regs.pf = cfg_data_i[PF_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/power_limited_current_solver_tb.sv
// Testbench top for the power-limited current solver: clock, reset, stimulus
// and verdict. Depends on plsolv_pkg, the block and power_limited_current_solver_chk.
module power_limited_current_solver_tb;
  import plsolv_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [XW-1:0]        m_axis_tdata;
  logic [ST_W-1:0]      m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [XW-1:0]        cfg_data_i = '0;
  int                   errors;
  int                   pending;
  int                   cyc = 0;
  bit                   hold_req = 1'b0;
  int                   sent = 0;

  always #10 clk_i = ~clk_i;
  always @(posedge clk_i) cyc <= cyc + 1;

  power_limited_current_solver uut (.*);

  power_limited_current_solver_chk chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // Output side: random backpressure, a quiet window, and one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (cyc > 2500 && cyc < 5500) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= 25;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [XW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(logic [XW-1:0] p, logic [XW-1:0] w, logic [XW-1:0] req);
    if (!(cyc > 2500 && cyc < 5500)) begin
      while ($urandom_range(0, 99) < 25) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {req, w, p};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [XW-1:0] small_signed(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  initial begin
    logic [XW-1:0] dp[5] = '{32'd0, 32'hffffffff, 32'd1, 32'h7fffffff, 32'h80000000};
    logic [XW-1:0] dw[4] = '{32'd0, 32'h7fffffff, 32'h80000000, 32'h00030000};
    logic [XW-1:0] dr[5] = '{32'd0, 32'd1, 32'hffffffff, 32'h7fffffff, 32'h80000000};
    logic [XW-1:0] p, w, r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: ;  // reset values: factor at one, everything passes
        1: begin
          write_reg(CFG_K0, 32'h00008000);
          write_reg(CFG_K1, 32'h00000100);
          write_reg(CFG_K2, 32'h00010000);
          write_reg(CFG_A0, 32'h00020000);
          write_reg(CFG_PF, 32'h00008000);
        end
        2: write_reg(CFG_K2, 32'd0);
        3: begin
          write_reg(CFG_K2, 32'hfffd0000);
          write_reg(CFG_PF, 32'd0);
        end
        4: begin
          write_reg(CFG_K0, 32'h7fffffff);
          write_reg(CFG_K1, 32'h80000000);
          write_reg(CFG_K2, 32'h80000000);
          write_reg(CFG_A0, 32'h7fffffff);
          write_reg(CFG_PF, 32'd65535);
        end
        5: begin
          write_reg(CFG_K0, 32'h80000000);
          write_reg(CFG_K1, 32'h7fffffff);
          write_reg(CFG_K2, 32'd1);
          write_reg(CFG_A0, 32'h80000000);
          write_reg(CFG_PF, 32'd0);
        end
        9: begin
          write_reg(CFG_PF, 32'h0001ffff);
          write_reg(cfg_idx_e'(3'd5), 32'h0);  // unmapped index, ignored
          write_reg(cfg_idx_e'(3'd7), 32'h12345678);
        end
        default: begin
          write_reg(CFG_K0, small_signed(32'h00040000));
          write_reg(CFG_K1, small_signed(32'h00001000));
          write_reg(CFG_K2, small_signed(32'h00040000) | 32'd1);
          write_reg(CFG_A0, small_signed(32'h00100000));
          write_reg(CFG_PF, $urandom_range(0, 65536));
        end
      endcase
      if (ph == 1) begin
        for (int i = 0; i < 20; i++)
          send_item(dp[i % 5], dw[i % 4], dr[(i / 4) % 5]);
        hold_req = 1'b1;
      end
      for (int i = 0; i < 145; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          p = $urandom;
          w = $urandom;
        end else begin
          p = $urandom_range(1, 1 << 22);
          w = small_signed(1 << 20);
        end
        r = $urandom_range(0, 3) == 0 ? small_signed(1 << 18) : $urandom;
        send_item(p, w, r);
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end
    $display("Covered %0d items over 10 register settings: pass-through, k2 zero,", sent);
    $display("negative k2, no-root and root selection cases, with stalls on both sides.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
